/* rtl/llf_pkg.sv */
// ----------------------------------------------------------------------------
// llf_pkg
// Shared types, codes and helpers of the least-laxity-first scheduler.
// ----------------------------------------------------------------------------
package llf_pkg;

  localparam int IN_W  = 40;
  localparam int OUT_W = 112;
  localparam int LAX_W = 35;

  localparam logic signed [LAX_W-1:0] LAX_MAX = LAX_W'(64'sd2147483647);

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_READY   = 2'd0,
    ST_RUNNING = 2'd1,
    ST_WAITING = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_LAX0,
    S_SCAN1,
    S_SCAN2,
    S_PREEMPT,
    S_EXEC,
    S_OUT
  } state_t;

  function automatic logic signed [LAX_W-1:0] laxity(input logic [31:0] dl,
                                                     input logic [31:0] t,
                                                     input logic [15:0] rem);
    laxity = $signed({3'b000, dl}) - $signed({3'b000, t}) - $signed({19'd0, rem});
  endfunction

endpackage

/* rtl/llf_div.sv */
// ----------------------------------------------------------------------------
// llf_div
// Bit-serial remainder unit: 32-bit dividend by 16-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module llf_div import llf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] remainder
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] num_r, num_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [16:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, num_r[31]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      num_nxt = {num_r[30:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = 16'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[15:0];
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

/* rtl/least_laxity_first_scheduler.sv */
// ----------------------------------------------------------------------------
// least_laxity_first_scheduler
// Preemptive least-laxity-first scheduler for periodic tasks.
// ----------------------------------------------------------------------------
// Tick request: result set by two walks over the slots; a new request is taken
// only once the result of the last one has been taken.
// Load request: result set by the 32-step remainder unit. One request in flight
// at a time.
// Synchronous active-low reset: all tasks ready, counters zero, none running,
// task_count 8.
module least_laxity_first_scheduler import llf_pkg::*; #(
  parameter int MAX_TASKS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // mode[1:0], task_index[4:2], period[20:5], exec_ticks[36:21], zero pad
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // running_valid[0], running_task[3:1], preempted[4], preempted_task[7:5],
  // missed_mask[15:8], task_preemptions[31:16], task_misses[47:32],
  // preempt_total[79:48], total_misses[111:80]
  output logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [1:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = IW + 1;

  state_t state_r, state_nxt;

  logic [15:0] per_a   [MAX_TASKS];
  logic [15:0] exe_a   [MAX_TASKS];
  logic [31:0] dl_a    [MAX_TASKS];
  logic [15:0] rem_a   [MAX_TASKS];
  logic [15:0] phase_a [MAX_TASKS];
  status_t     stat_a  [MAX_TASKS];
  logic [15:0] pcnt_a  [MAX_TASKS];
  logic [15:0] mcnt_a  [MAX_TASKS];

  logic [3:0]  task_count_r;
  logic        active_r;
  logic [IW-1:0] running_r;
  logic [31:0] tick_r, sum_pre_r, sum_miss_r;
  logic [CW-1:0] ctr_r;
  logic signed [LAX_W-1:0] best_r;
  logic        found_r;
  logic [IW-1:0] pick_r;

  mode_t       mode_r;
  logic [2:0]  idx_r;
  logic [15:0] per_r, exe_r;

  logic        out_valid_r;
  logic        rv_r, pv_r;
  logic [2:0]  rt_r, pt_r;
  logic [7:0]  mask_r;
  logic [15:0] tp_r, tm_r;

  logic        in_acc, idx_ok, part, last, divides, div_start, div_done;
  logic [IW-1:0] addr, islot;
  logic [31:0] n_w;
  logic [15:0] div_rem;
  logic signed [LAX_W-1:0] lax;

  assign in_acc = in_tvalid && in_tready;
  assign islot  = IW'(idx_r);
  assign idx_ok = 32'(idx_r) < MAX_TASKS;
  assign n_w    = (32'(task_count_r) > MAX_TASKS) ? MAX_TASKS : 32'(task_count_r);
  assign part   = 32'(ctr_r) < n_w;
  assign last   = ctr_r == CW'(MAX_TASKS - 1);

  always_comb begin
    in_tready = (state_r == S_IDLE) && !out_valid_r;
    addr      = (state_r == S_LAX0) ? running_r : ctr_r[IW-1:0];
    div_start = (state_r == S_LOAD) && idx_ok;
  end

  assign lax     = laxity(dl_a[addr], tick_r, rem_a[addr]);
  assign divides = (per_a[addr] == 16'd0) ? (tick_r == 32'd0) : (phase_a[addr] == 16'd0);

  llf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (tick_r),
    .divisor   (per_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (mode_t'(in_tdata[1:0]))
            MODE_TICK: state_nxt = S_LAX0;
            MODE_LOAD: state_nxt = S_LOAD;
            default:   state_nxt = S_OUT;
          endcase
        end
      end
      S_LOAD:    state_nxt = idx_ok ? S_DIV : S_OUT;
      S_DIV:     state_nxt = div_done ? S_OUT : S_DIV;
      S_LAX0:    state_nxt = S_SCAN1;
      S_SCAN1:   state_nxt = last ? S_SCAN2 : S_SCAN1;
      S_SCAN2:   state_nxt = last ? S_PREEMPT : S_SCAN2;
      S_PREEMPT: state_nxt = S_EXEC;
      S_EXEC:    state_nxt = S_OUT;
      S_OUT:     state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      task_count_r <= 4'd8;
      active_r     <= 1'b0;
      running_r    <= '0;
      tick_r       <= '0;
      sum_pre_r    <= '0;
      sum_miss_r   <= '0;
      out_valid_r  <= 1'b0;
      ctr_r        <= '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        stat_a[i] <= ST_READY;
        pcnt_a[i] <= '0;
        mcnt_a[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0) begin
        task_count_r <= cfg_pwdata[3:0];
      end
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            mode_r <= mode_t'(in_tdata[1:0]);
            idx_r  <= in_tdata[4:2];
            per_r  <= in_tdata[20:5];
            exe_r  <= in_tdata[36:21];
            rv_r <= 1'b0; rt_r <= '0; pv_r <= 1'b0; pt_r <= '0;
            mask_r <= '0; tp_r <= '0; tm_r <= '0;
            ctr_r <= '0;
          end
        end
        S_LOAD: begin
          if (idx_ok) begin
            per_a[islot]  <= per_r;
            exe_a[islot]  <= exe_r;
            dl_a[islot]   <= {16'd0, per_r};
            rem_a[islot]  <= exe_r;
            stat_a[islot] <= ST_READY;
            pcnt_a[islot] <= '0;
            mcnt_a[islot] <= '0;
            if (active_r && running_r == islot) begin
              active_r <= 1'b0;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            phase_a[islot] <= div_rem;
          end
        end
        S_LAX0: begin
          best_r  <= active_r ? lax : LAX_MAX;
          found_r <= 1'b0;
          pick_r  <= '0;
          ctr_r   <= '0;
        end
        S_SCAN1: begin
          if (part) begin
            if (stat_a[addr] == ST_READY && dl_a[addr] < tick_r) begin
              if (mcnt_a[addr] != 16'hFFFF) mcnt_a[addr] <= mcnt_a[addr] + 16'd1;
              if (sum_miss_r != 32'hFFFF_FFFF) sum_miss_r <= sum_miss_r + 32'd1;
              dl_a[addr] <= dl_a[addr] + {16'd0, per_a[addr]};
              if (32'(ctr_r) < 8) mask_r[3'(ctr_r)] <= 1'b1;
            end else if (stat_a[addr] == ST_WAITING && divides) begin
              stat_a[addr] <= ST_READY;
            end
          end
          if (tick_r == 32'hFFFF_FFFF || 17'(phase_a[addr]) + 17'd1 == {1'b0, per_a[addr]}) begin
            phase_a[addr] <= '0;
          end else begin
            phase_a[addr] <= phase_a[addr] + 16'd1;
          end
          ctr_r <= last ? '0 : ctr_r + CW'(1);
        end
        S_SCAN2: begin
          if (part && stat_a[addr] == ST_READY && lax < best_r) begin
            best_r  <= lax;
            pick_r  <= addr;
            found_r <= 1'b1;
          end
          ctr_r <= last ? '0 : ctr_r + CW'(1);
        end
        S_PREEMPT: begin
          if (found_r) begin
            if (active_r) begin
              if (pcnt_a[running_r] != 16'hFFFF) begin
                pcnt_a[running_r] <= pcnt_a[running_r] + 16'd1;
              end
              if (sum_pre_r != 32'hFFFF_FFFF) sum_pre_r <= sum_pre_r + 32'd1;
              stat_a[running_r] <= ST_READY;
              pv_r <= 1'b1;
              pt_r <= 3'(running_r);
            end
            running_r      <= pick_r;
            stat_a[pick_r] <= ST_RUNNING;
            active_r       <= 1'b1;
          end
        end
        S_EXEC: begin
          if (active_r) begin
            rv_r <= 1'b1;
            rt_r <= 3'(running_r);
            if (rem_a[running_r] <= 16'd1) begin
              dl_a[running_r]   <= dl_a[running_r] + {16'd0, per_a[running_r]};
              rem_a[running_r]  <= exe_a[running_r];
              stat_a[running_r] <= ST_WAITING;
              active_r          <= 1'b0;
            end else begin
              rem_a[running_r] <= rem_a[running_r] - 16'd1;
            end
          end
          tick_r <= tick_r + 32'd1;
        end
        S_OUT: begin
          if (mode_r == MODE_QUERY && idx_ok) begin
            tp_r <= pcnt_a[islot];
            tm_r <= mcnt_a[islot];
          end
          out_valid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {sum_miss_r, sum_pre_r, tm_r, tp_r, mask_r, pt_r, pv_r, rt_r, rv_r};
  assign cfg_prdata = {28'd0, task_count_r};
  assign cfg_pready = 1'b1;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE)
    else $error("ready outside idle");
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("second request accepted while busy");
  a_run_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> 32'(running_r) < MAX_TASKS)
    else $error("running slot out of range");
  a_pick_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PREEMPT && found_r) |-> stat_a[pick_r] == ST_READY)
    else $error("picked task not ready");

endmodule
